/* rtl/ppvc_pkg.sv */
package ppvc_pkg;

  // internal widths of the vectoring datapath
  localparam int unsigned XyW      = 34;
  localparam int unsigned AngW     = 32;
  localparam int unsigned MaxCells = 24;

  // 2^32-scaled inverse cordic gain; >> 46 gives integer distance
  localparam logic [31:0] RhoScale = 32'h9B74_EDA8;

  localparam logic [31:0] ATAN_TAB [MaxCells] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic [2:0] {
    CFG_GAIN_DISTANCE      = 3'd0,
    CFG_GAIN_BEARING       = 3'd1,
    CFG_GAIN_FINAL_HEADING = 3'd2,
    CFG_MAX_LINEAR         = 3'd3,
    CFG_MAX_ROTATIONAL     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0]        gain_distance;
    logic [15:0]        gain_bearing;
    logic signed [15:0] gain_final_heading;
    logic [14:0]        max_linear;
    logic [14:0]        max_rotational;
  } cfg_t;

  // heading data and zero-offset flag riding the vectoring chain
  typedef struct packed {
    logic [15:0] pose_heading;
    logic [15:0] heading_diff;
    logic        zero_offset;
  } side_t;

  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic [AngW-1:0]       z;
    side_t                 side;
  } vec_t;

  typedef struct packed {
    logic signed [15:0] linear_cmd;
    logic signed [15:0] rotational_cmd;
    logic               reverse_mode;
  } result_t;

endpackage

/* rtl/polar_pose_velocity_controller_core.sv */
// Polar pose controller: from a current and a target pose it forms distance and bearing
// with a pipelined vectoring CORDIC, drives forward or backward with saturated linear and
// rotation commands, and flags the backward case. One request is taken per clock while the
// pipeline is not held. A request passes an input stage, the chain of CORDIC cells (capped at
// 24 CORDIC cells), three post stages and the output register. The whole pipeline holds only
// while its last stage has a result the output register cannot take, so requests keep
// entering while a result waits if bubbles remain.
// Configuration writes are always accepted and should be made with no request in flight.
module polar_pose_velocity_controller_core #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] target_x_i,
  input  logic signed [15:0] target_y_i,
  input  logic signed [15:0] target_heading_i,
  input  logic signed [15:0] pose_x_i,
  input  logic signed [15:0] pose_y_i,
  input  logic signed [15:0] pose_heading_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] linear_cmd_o,
  output logic signed [15:0] rotational_cmd_o,
  output logic               reverse_mode_o
);

  localparam int unsigned NumCells =
    (CORDIC_STAGES > ppvc_pkg::MaxCells) ? ppvc_pkg::MaxCells : CORDIC_STAGES;

  ppvc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_distance      <= 16'd4096;
      cfg_q.gain_bearing       <= 16'd4096;
      cfg_q.gain_final_heading <= -16'sd2048;
      cfg_q.max_linear         <= 15'd256;
      cfg_q.max_rotational     <= 15'd8192;
    end else if (cfg_valid_i) begin
      case (ppvc_pkg::cfg_idx_e'(cfg_index_i))
        ppvc_pkg::CFG_GAIN_DISTANCE:      cfg_q.gain_distance      <= cfg_data_i;
        ppvc_pkg::CFG_GAIN_BEARING:       cfg_q.gain_bearing       <= cfg_data_i;
        ppvc_pkg::CFG_GAIN_FINAL_HEADING: cfg_q.gain_final_heading <= $signed(cfg_data_i);
        ppvc_pkg::CFG_MAX_LINEAR:         cfg_q.max_linear         <= cfg_data_i[14:0];
        ppvc_pkg::CFG_MAX_ROTATIONAL:     cfg_q.max_rotational     <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic              adv;
  logic              last_valid;
  ppvc_pkg::result_t result;
  logic              out_valid_q;
  ppvc_pkg::result_t out_q;

  // hold only when the last stage has a result and the output register is full
  assign adv        = !last_valid || !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // input stage: offsets and pre-rotation into the right half plane
  logic signed [16:0] dx, dy;
  logic signed [ppvc_pkg::XyW-1:0] xs, ys;
  ppvc_pkg::vec_t vec0_d, vec0_q;
  logic           v0_q;

  always_comb begin
    dx = 17'(target_x_i) - 17'(pose_x_i);
    dy = 17'(target_y_i) - 17'(pose_y_i);
    xs = {{(ppvc_pkg::XyW-31){dx[16]}}, dx, 14'd0};
    ys = {{(ppvc_pkg::XyW-31){dy[16]}}, dy, 14'd0};
    vec0_d.side.pose_heading = pose_heading_i;
    vec0_d.side.heading_diff = target_heading_i - pose_heading_i;
    vec0_d.side.zero_offset  = (dx == 17'sd0) && (dy == 17'sd0);
    if (dx < 0) begin
      vec0_d.x = -xs;
      vec0_d.y = -ys;
      vec0_d.z = 32'h8000_0000;
    end else begin
      vec0_d.x = xs;
      vec0_d.y = ys;
      vec0_d.z = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vec0_q <= vec0_d;
    end
  end

  logic           chain_valid [NumCells+1];
  ppvc_pkg::vec_t chain_vec   [NumCells+1];

  assign chain_valid[0] = v0_q;
  assign chain_vec[0]   = vec0_q;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    ppvc_cordic_cell #(
      .STAGE(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .valid_i(chain_valid[g]),
      .vec_i  (chain_vec[g]),
      .valid_o(chain_valid[g+1]),
      .vec_o  (chain_vec[g+1])
    );
  end

  ppvc_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (chain_valid[NumCells]),
    .vec_i   (chain_vec[NumCells]),
    .cfg_i   (cfg_q),
    .valid_o (last_valid),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && last_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_valid) begin
      out_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign linear_cmd_o     = out_q.linear_cmd;
  assign rotational_cmd_o = out_q.rotational_cmd;
  assign reverse_mode_o   = out_q.reverse_mode;

endmodule

/* rtl/ppvc_cordic_cell.sv */
module ppvc_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  ppvc_pkg::vec_t   vec_i,
  output logic             valid_o,
  output ppvc_pkg::vec_t   vec_o
);

  logic           valid_q;
  ppvc_pkg::vec_t vec_d, vec_q;
  logic signed [ppvc_pkg::XyW-1:0] xs, ys;

  always_comb begin
    xs = vec_i.y >>> STAGE;
    ys = vec_i.x >>> STAGE;
    vec_d = vec_i;
    if (vec_i.y > 0) begin
      vec_d.x = vec_i.x + xs;
      vec_d.y = vec_i.y - ys;
      vec_d.z = vec_i.z + ppvc_pkg::ATAN_TAB[STAGE];
    end else begin
      vec_d.x = vec_i.x - xs;
      vec_d.y = vec_i.y + ys;
      vec_d.z = vec_i.z - ppvc_pkg::ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

/* rtl/ppvc_post.sv */
module ppvc_post (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  ppvc_pkg::vec_t      vec_i,
  input  ppvc_pkg::cfg_t      cfg_i,
  output logic                valid_o,
  output ppvc_pkg::result_t   result_o
);

  // stage 1: magnitude scaling product and rounded bearing
  logic        v1_q;
  logic [63:0] prod_q;
  logic [15:0] bear_q;
  ppvc_pkg::side_t side1_q;
  logic [31:0] x_clip;
  logic [31:0] z_round;

  // stage 2: rho and wrapped angle errors
  logic        v2_q;
  logic [17:0] rho_d, rho_q;
  logic signed [15:0] alpha_raw, alpha_d, alpha_q, beta_d, beta_q;
  logic        rev_d, rev_q;
  logic [64:0] prod_rnd;

  // stage 3: gain products
  logic        v3_q;
  logic [33:0]        mv_q;
  logic signed [32:0] ma_q;
  logic signed [31:0] mb_q;
  logic               rev3_q;

  // final rounding and clamps
  logic [34:0]        v_rnd;
  logic signed [23:0] v_s, lin_lim, lin_c;
  logic signed [35:0] w_sum;
  logic signed [23:0] w_s, rot_lim, rot_c;

  always_comb begin
    x_clip  = vec_i.x[ppvc_pkg::XyW-1] ? 32'd0 : vec_i.x[31:0];
    z_round = vec_i.z + 32'h0000_8000;
    if (vec_i.side.zero_offset) begin
      x_clip  = 32'd0;
      z_round = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q  <= 64'(x_clip) * 64'(ppvc_pkg::RhoScale);
      bear_q  <= z_round[31:16];
      side1_q <= vec_i.side;
    end
  end

  always_comb begin
    prod_rnd  = {1'b0, prod_q} + 65'(64'd1 << 45);
    rho_d     = prod_rnd[63:46];
    alpha_raw = $signed(bear_q - side1_q.pose_heading);
    beta_d    = $signed(side1_q.heading_diff - alpha_raw);
    rev_d     = !((alpha_raw > -16'sd16384) && (alpha_raw < 16'sd16384));
    // adding pi to a binary angle flips its top bit
    alpha_d   = rev_d ? {~alpha_raw[15], alpha_raw[14:0]} : alpha_raw;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rho_q   <= rho_d;
      alpha_q <= alpha_d;
      beta_q  <= beta_d;
      rev_q   <= rev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mv_q   <= 34'(cfg_i.gain_distance) * 34'(rho_q);
      ma_q   <= $signed({17'd0, cfg_i.gain_bearing}) * 33'(alpha_q);
      mb_q   <= 32'(cfg_i.gain_final_heading) * 32'(beta_q);
      rev3_q <= rev_q;
    end
  end

  always_comb begin
    v_rnd   = {1'b0, mv_q} + 35'd2048;
    v_s     = $signed({1'b0, v_rnd[34:12]});
    if (rev3_q) begin
      v_s = -v_s;
    end
    lin_lim = $signed({9'd0, cfg_i.max_linear});
    if (v_s > lin_lim) begin
      lin_c = lin_lim;
    end else if (v_s < -lin_lim) begin
      lin_c = -lin_lim;
    end else begin
      lin_c = v_s;
    end

    w_sum   = 36'(ma_q) + 36'(mb_q) + 36'sd2048;
    w_s     = w_sum[35:12];
    rot_lim = $signed({9'd0, cfg_i.max_rotational});
    if (w_s > rot_lim) begin
      rot_c = rot_lim;
    end else if (w_s < -rot_lim) begin
      rot_c = -rot_lim;
    end else begin
      rot_c = w_s;
    end

    result_o.linear_cmd     = lin_c[15:0];
    result_o.rotational_cmd = rot_c[15:0];
    result_o.reverse_mode   = rev3_q;
  end

  assign valid_o = v3_q;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CordicStages = 16;
  localparam int unsigned NumCells = (CordicStages > 24) ? 24 : CordicStages;
  localparam int unsigned Latency = NumCells + 5;
  localparam int unsigned CycleLimit = 500000;

  // register indexes that decode to nothing
  localparam logic [2:0] CfgSpareLo = 3'd5;
  localparam logic [2:0] CfgSpareHi = 3'd7;

  localparam int QuarterTurn = 16384;
  localparam logic [15:0] HalfTurn = 16'h8000;

  // arctan(2^-i) with 2^32 as a full turn
  localparam logic [31:0] ArctanSteps [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_heading;
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] pose_heading;
  } pose_req_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [15:0] target_x_i;
  logic signed [15:0] target_y_i;
  logic signed [15:0] target_heading_i;
  logic signed [15:0] pose_x_i;
  logic signed [15:0] pose_y_i;
  logic signed [15:0] pose_heading_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [15:0] linear_cmd_o;
  logic signed [15:0] rotational_cmd_o;
  logic               reverse_mode_o;

  ppvc_pkg::cfg_t    gains = '{gain_distance: 16'd4096, gain_bearing: 16'd4096,
                               gain_final_heading: -16'sd2048, max_linear: 15'd256,
                               max_rotational: 15'd8192};
  ppvc_pkg::result_t predicted_cmds [$];

  int requests_sent = 0;
  int cmds_checked = 0;
  int settings_used = 1;
  int mismatch_count = 0;
  int cycle_count = 0;
  int tx_gap_max = 11;
  int rx_gap_max = 11;
  int rx_hold = 0;

  polar_pose_velocity_controller_core #(
    .CORDIC_STAGES(CordicStages)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .target_x_i      (target_x_i),
    .target_y_i      (target_y_i),
    .target_heading_i(target_heading_i),
    .pose_x_i        (pose_x_i),
    .pose_y_i        (pose_y_i),
    .pose_heading_i  (pose_heading_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .linear_cmd_o    (linear_cmd_o),
    .rotational_cmd_o(rotational_cmd_o),
    .reverse_mode_o  (reverse_mode_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint clamp_mag(input longint val, input longint lim);
    if (val > lim) return lim;
    if (val < -lim) return -lim;
    return val;
  endfunction

  // vectoring cordic: distance as an integer in input units and bearing as a 16-bit binary angle
  function automatic void polar_of(input int dx, input int dy, output longint rho,
                                   output logic [15:0] bearing);
    longint      x, y, xs, ys;
    logic [31:0] z, zr;
    logic [63:0] prod;
    int          i;
    rho = 0;
    bearing = '0;
    if (dx == 0 && dy == 0) return;
    x = longint'(dx) * 16384;
    y = longint'(dy) * 16384;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (i = 0; i < NumCells; i++) begin
      xs = y >>> i;
      ys = x >>> i;
      if (y > 0) begin
        x = x + xs;
        y = y - ys;
        z = z + ArctanSteps[i];
      end else begin
        x = x - xs;
        y = y + ys;
        z = z - ArctanSteps[i];
      end
    end
    if (x < 0) x = 0;
    prod = 64'(x) * 64'h0000_0000_9B74_EDA8 + 64'h0000_2000_0000_0000;
    rho = longint'(prod >> 46);
    zr = z + 32'h0000_8000;
    bearing = zr[31:16];
  endfunction

  function automatic ppvc_pkg::result_t predict_cmd(input pose_req_t r,
                                                    input ppvc_pkg::cfg_t g);
    ppvc_pkg::result_t  res;
    int                 dx, dy;
    longint             rho, v, w;
    logic [15:0]        bearing;
    logic signed [15:0] alpha, beta;
    logic               rev;
    dx = int'(r.target_x) - int'(r.pose_x);
    dy = int'(r.target_y) - int'(r.pose_y);
    polar_of(dx, dy, rho, bearing);
    alpha = bearing - r.pose_heading;
    beta = r.target_heading - r.pose_heading - alpha;
    rev = !(alpha > -QuarterTurn && alpha < QuarterTurn);
    // backward branch turns toward the reversed bearing, beta stays as formed
    if (rev) alpha = alpha + HalfTurn;
    v = (longint'(g.gain_distance) * rho + 2048) >>> 12;
    if (rev) v = -v;
    v = clamp_mag(v, longint'(g.max_linear));
    w = longint'(g.gain_bearing) * longint'(alpha)
      + longint'(g.gain_final_heading) * longint'(beta);
    w = clamp_mag((w + 2048) >>> 12, longint'(g.max_rotational));
    res.linear_cmd = v[15:0];
    res.rotational_cmd = w[15:0];
    res.reverse_mode = rev;
    return res;
  endfunction

  function automatic pose_req_t mk_pose(input int tx, input int ty, input int th,
                                        input int px, input int py, input int ph);
    pose_req_t r;
    r.target_x = tx[15:0];
    r.target_y = ty[15:0];
    r.target_heading = th[15:0];
    r.pose_x = px[15:0];
    r.pose_y = py[15:0];
    r.pose_heading = ph[15:0];
    return r;
  endfunction

  // a mix of full-range poses, near targets, coincident poses and headings
  // straddling the forward/backward boundary
  function automatic pose_req_t rand_pose();
    pose_req_t r;
    int        kind, span;
    r = pose_req_t'({$urandom, $urandom, $urandom});
    kind = $urandom_range(0, 9);
    span = (kind == 9) ? 8192 : 512;
    if (kind >= 4 && kind <= 6 || kind == 9) begin
      r.target_x = r.pose_x + 16'($urandom_range(0, 2 * span) - span);
      r.target_y = r.pose_y + 16'($urandom_range(0, 2 * span) - span);
    end else if (kind == 7) begin
      r.target_x = r.pose_x;
      r.target_y = r.pose_y;
    end else if (kind == 8) begin
      r.target_x = r.pose_x + 16'($urandom_range(1, 4000));
      r.target_y = r.pose_y;
      r.pose_heading = 16'($urandom_range(0, 1) ? QuarterTurn : -QuarterTurn)
                     + 16'($urandom_range(0, 2) - 1);
    end
    return r;
  endfunction

  task automatic send_pose(input pose_req_t r);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    target_x_i = r.target_x;
    target_y_i = r.target_y;
    target_heading_i = r.target_heading;
    pose_x_i = r.pose_x;
    pose_y_i = r.pose_y;
    pose_heading_i = r.pose_heading;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pose(rand_pose());
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (predicted_cmds.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_gains(input logic [15:0] kr, input logic [15:0] ka,
                           input logic [15:0] kb, input logic [15:0] vmax,
                           input logic [15:0] wmax);
    wait_idle();
    write_reg(ppvc_pkg::CFG_GAIN_DISTANCE, kr);
    write_reg(ppvc_pkg::CFG_GAIN_BEARING, ka);
    write_reg(ppvc_pkg::CFG_GAIN_FINAL_HEADING, kb);
    write_reg(ppvc_pkg::CFG_MAX_LINEAR, vmax);
    write_reg(ppvc_pkg::CFG_MAX_ROTATIONAL, wmax);
    settings_used++;
  endtask

  task automatic test_directed_poses();
    send_pose(mk_pose(0, 0, 0, 0, 0, 0));
    send_pose(mk_pose(700, -300, 12000, 700, -300, -5000));
    send_pose(mk_pose(32767, 0, 0, -32768, 0, 0));
    send_pose(mk_pose(-32768, 0, 0, 32767, 0, 0));
    send_pose(mk_pose(0, 32767, 0, 0, -32768, 0));
    send_pose(mk_pose(0, -32768, 0, 0, 32767, 0));
    send_pose(mk_pose(32767, 32767, 32767, -32768, -32768, -32768));
    send_pose(mk_pose(-32768, -32768, -32768, 32767, 32767, 32767));
    // bearing zero against headings at and just inside a quarter turn
    send_pose(mk_pose(256, 0, 0, 0, 0, 16384));
    send_pose(mk_pose(256, 0, 0, 0, 0, -16384));
    send_pose(mk_pose(256, 0, 0, 0, 0, 16383));
    send_pose(mk_pose(256, 0, 0, 0, 0, -16383));
    // heading difference wraps around a half turn
    send_pose(mk_pose(40, 30, 32767, 0, 0, -32768));
    send_pose(mk_pose(40, 30, -32768, 0, 0, 32767));
    send_pose(mk_pose(100, 50, 2000, 0, 0, 0));
    send_pose(mk_pose(-100, 20, -3000, 0, 0, 0));
    send_pose(mk_pose(0, 0, -32768, -1, -1, 32767));
    send_pose(mk_pose(1, 1, 0, 0, 0, 0));
  endtask

  task automatic test_register_extremes();
    set_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_random(40);
    // limits written as all ones must mask to 15 bits
    set_gains(16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF);
    send_random(40);
    set_gains(16'hFFFF, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_random(40);
    set_gains(16'h0001, 16'h0001, 16'hFFFF, 16'h0001, 16'h0001);
    send_random(40);
    set_gains(16'h1000, 16'h1000, 16'hF800, 16'h0100, 16'h2000);
    send_random(40);
  endtask

  task automatic test_spare_index();
    set_gains(16'h2345, 16'h0ABC, 16'h0421, 16'h1234, 16'h0F00);
    write_reg(CfgSpareLo, 16'h0000);
    write_reg(CfgSpareHi, 16'h0000);
    send_random(30);
  endtask

  task automatic test_random_settings();
    repeat (12) begin
      set_gains($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8192)),
                $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8192)),
                16'($urandom),
                16'($urandom),
                $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2048)));
      // some phases run without idling on one or both sides
      tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      send_random(130);
    end
    tx_gap_max = 11;
    rx_gap_max = 11;
  endtask

  task automatic test_output_stall();
    wait_idle();
    tx_gap_max = 0;
    rx_hold = 300;
    send_random(150);
    tx_gap_max = 11;
  endtask

  // sink side: random stall before each result, or a long hold when asked
  initial begin : result_sink
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = (rx_hold > 0) ? rx_hold : $urandom_range(0, rx_gap_max);
      rx_hold = 0;
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i = 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : scoreboard
    ppvc_pkg::result_t want;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ppvc_pkg::CFG_GAIN_DISTANCE:      gains.gain_distance = cfg_data_i;
        ppvc_pkg::CFG_GAIN_BEARING:       gains.gain_bearing = cfg_data_i;
        ppvc_pkg::CFG_GAIN_FINAL_HEADING: gains.gain_final_heading = cfg_data_i;
        ppvc_pkg::CFG_MAX_LINEAR:         gains.max_linear = cfg_data_i[14:0];
        ppvc_pkg::CFG_MAX_ROTATIONAL:     gains.max_rotational = cfg_data_i[14:0];
        default: ;
      endcase
    end
    if (in_valid_i && in_ready_o) begin
      predicted_cmds.push_back(predict_cmd(mk_pose(target_x_i, target_y_i, target_heading_i,
                                                   pose_x_i, pose_y_i, pose_heading_i),
                                           gains));
    end
    if (out_valid_o && out_ready_i) begin
      if (predicted_cmds.size() == 0) begin
        $display("%0t unexpected result linear %0d rotational %0d reverse %0b", $time,
                 linear_cmd_o, rotational_cmd_o, reverse_mode_o);
        mismatch_count++;
      end else begin
        want = predicted_cmds.pop_front();
        cmds_checked++;
        if (linear_cmd_o !== want.linear_cmd) begin
          $display("%0t linear_cmd expected %0d got %0d", $time, want.linear_cmd,
                   linear_cmd_o);
          mismatch_count++;
        end
        if (rotational_cmd_o !== want.rotational_cmd) begin
          $display("%0t rotational_cmd expected %0d got %0d", $time, want.rotational_cmd,
                   rotational_cmd_o);
          mismatch_count++;
        end
        if (reverse_mode_o !== want.reverse_mode) begin
          $display("%0t reverse_mode expected %0b got %0b", $time, want.reverse_mode,
                   reverse_mode_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout with %0d results outstanding", predicted_cmds.size());
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    target_x_i = '0;
    target_y_i = '0;
    target_heading_i = '0;
    pose_x_i = '0;
    pose_y_i = '0;
    pose_heading_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_poses();
    test_register_extremes();
    test_spare_index();
    test_random_settings();
    test_output_stall();
    wait_idle();

    $display("sent %0d pose requests under %0d gain/limit settings", requests_sent,
             settings_used);
    $display("compared %0d commands, %0d mismatches", cmds_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
